// ===== design/tns_pkg.sv =====
// Shared types and constants of the threshold network step block.
package tns_pkg;

    localparam int NEURONS_DEF = 64;
    localparam int MAX_NEURONS = 64;
    localparam int CNT_W       = 7;
    localparam int HOLD_W      = 4;
    localparam int THR_W       = 11;
    localparam int WGT_W       = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int IN_DATA_W   = 80;
    localparam int OUT_DATA_W  = 80;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_START = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXC_COUNT  = 3'd0,
        CFG_EXC_HOLD   = 3'd1,
        CFG_INH_HOLD   = 3'd2,
        CFG_THRESHOLD  = 3'd3,
        CFG_EXC_WEIGHT = 3'd4,
        CFG_INH_WEIGHT = 3'd5
    } cfg_idx_t;

    // Control from the sequencer to every lane
    typedef struct packed {
        logic clear;
        logic acc_en;
        logic exc_src;
        logic mul_en;
    } lane_ctrl_t;

endpackage

// ===== design/tns_lane.sv =====
// One target-neuron lane: counts active in-links and decides firing.
module tns_lane
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  tns_pkg::lane_ctrl_t                    ctrl,
    input  logic                                   link,
    input  logic [tns_pkg::WGT_W-1:0]              exc_weight,
    input  logic [tns_pkg::WGT_W-1:0]              inh_weight,
    input  logic signed [tns_pkg::THR_W-1:0]       threshold,
    output logic                                   fire
);

    localparam int PROD_W = tns_pkg::CNT_W + tns_pkg::WGT_W;

    logic [tns_pkg::CNT_W-1:0] pos_reg, pos_next;
    logic [tns_pkg::CNT_W-1:0] neg_reg, neg_next;
    logic [PROD_W-1:0]         ppos_reg;
    logic [PROD_W-1:0]         pneg_reg;
    logic signed [PROD_W+1:0]  diff;

    always_comb
    begin
        pos_next = pos_reg;
        neg_next = neg_reg;
        if (ctrl.clear)
        begin
            pos_next = '0;
            neg_next = '0;
        end
        else if (ctrl.acc_en && link)
        begin
            if (ctrl.exc_src)
                pos_next = pos_reg + 1'b1;
            else
                neg_next = neg_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            neg_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            neg_reg <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            ppos_reg <= PROD_W'(pos_reg) * PROD_W'(exc_weight);
            pneg_reg <= PROD_W'(neg_reg) * PROD_W'(inh_weight);
        end
    end

    assign diff = $signed({2'b00, ppos_reg}) - $signed({2'b00, pneg_reg});
    assign fire = diff >= (PROD_W+2)'(threshold);

endmodule

// ===== design/tns_merge.sv =====
// Two-stage population count of excitatory and inhibitory active neurons.
module tns_merge #(
    parameter int NEURONS = tns_pkg::NEURONS_DEF
)
(
    input  logic                          clk,
    input  logic                          load,
    input  logic [NEURONS-1:0]            active,
    input  logic [tns_pkg::CNT_W-1:0]     exc_limit,
    output logic [tns_pkg::CNT_W-1:0]     exc_count,
    output logic [tns_pkg::CNT_W-1:0]     inh_count
);

    localparam int GROUPS = (NEURONS + 7) / 8;

    logic [GROUPS*8-1:0] act_pad;
    logic [GROUPS*8-1:0] exc_sel;
    logic [3:0]          eg_reg [GROUPS];
    logic [3:0]          ig_reg [GROUPS];

    always_comb
    begin
        act_pad = '0;
        act_pad[NEURONS-1:0] = active;
        for (int i = 0; i < GROUPS * 8; i++)
            exc_sel[i] = (tns_pkg::CNT_W'(i) < exc_limit);
    end

    // Count each group of eight
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int g = 0; g < GROUPS; g++)
            begin
                logic [3:0] e;
                logic [3:0] n;
                e = '0;
                n = '0;
                for (int b = 0; b < 8; b++)
                begin
                    if (act_pad[g*8+b] && exc_sel[g*8+b])
                        e = e + 1'b1;
                    if (act_pad[g*8+b] && !exc_sel[g*8+b])
                        n = n + 1'b1;
                end
                eg_reg[g] <= e;
                ig_reg[g] <= n;
            end
        end
    end

    always_comb
    begin
        exc_count = '0;
        inh_count = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            exc_count = exc_count + tns_pkg::CNT_W'(eg_reg[g]);
            inh_count = inh_count + tns_pkg::CNT_W'(ig_reg[g]);
        end
    end

endmodule

// ===== design/threshold_network_step.sv =====
// Threshold network step: top level with sequencer, adjacency memory and lanes.
// A tick runs from the accepting edge until the result beat is offered: the adjacency
// memory gives one source row per cycle and all target lanes add that row at once,
// then products, compare and a two-stage count follow. Start and other items go straight
// to the count; an adjacency write first reads and rewrites its row, skipping the write
// if an index is out of range. The next item can be taken once the result is offered.
// Adjacency rows carry a valid bit each, so there is no clearing pass after reset.
// An item is taken while the previous result still waits in the output register.
module threshold_network_step #(
    parameter int NEURONS = tns_pkg::NEURONS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // source_index[5:0], target_index[11:6], link_present[12], activity_mask[76:13]
    input  logic [tns_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // state_mask[63:0], active_excitatory[70:64], active_inhibitory[77:71]
    output logic [tns_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tns_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tns_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IW = $clog2(NEURONS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADJ_RD,
        ST_ADJ_WR,
        ST_TIMERS,
        ST_ROWS,
        ST_DRAIN,
        ST_MUL,
        ST_FIRE,
        ST_CNT1,
        ST_CNT2
    } state_t;

    state_t state_reg;

    // Configuration
    logic [tns_pkg::CNT_W-1:0]         exc_cnt_reg;
    logic [tns_pkg::HOLD_W-1:0]        exc_hold_reg;
    logic [tns_pkg::HOLD_W-1:0]        inh_hold_reg;
    logic signed [tns_pkg::THR_W-1:0]  thr_reg;
    logic [tns_pkg::WGT_W-1:0]         exc_wgt_reg;
    logic [tns_pkg::WGT_W-1:0]         inh_wgt_reg;

    // Held item
    logic [5:0]                        src_reg;
    logic [5:0]                        tgt_reg;
    logic                              bit_reg;
    logic [NEURONS-1:0]                mask_reg;

    logic [NEURONS-1:0]                active_reg;
    logic [tns_pkg::HOLD_W-1:0]        timer_reg [NEURONS];
    logic [NEURONS-1:0]                src_act_reg;
    logic [IW-1:0]                     rd_cnt_reg;
    logic                              pend_reg;
    logic [IW-1:0]                     pend_idx_reg;

    logic                              out_valid_reg;
    logic [tns_pkg::OUT_DATA_W-1:0]    out_data_reg;

    // Adjacency memory
    logic [NEURONS-1:0]                adj_mem [NEURONS];
    logic [NEURONS-1:0]                row_valid_reg;
    logic [NEURONS-1:0]                row_q_reg;
    logic                              row_ok_reg;
    logic                              mem_rd;
    logic [IW-1:0]                     mem_rd_addr;
    logic                              mem_wr;
    logic [NEURONS-1:0]                mem_wr_row;

    logic [tns_pkg::CNT_W-1:0]         ne;
    logic                              in_take;
    logic                              idx_ok;
    logic                              out_free;
    tns_pkg::lane_ctrl_t               lane_ctrl;
    logic [NEURONS-1:0]                row_links;
    logic [NEURONS-1:0]                fire;
    logic [tns_pkg::CNT_W-1:0]         exc_count;
    logic [tns_pkg::CNT_W-1:0]         inh_count;
    logic [tns_pkg::MAX_NEURONS-1:0]   state_wide;

    assign ne = (exc_cnt_reg > tns_pkg::CNT_W'(NEURONS)) ? tns_pkg::CNT_W'(NEURONS)
                                                         : exc_cnt_reg;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign idx_ok        = ({1'b0, src_reg} < tns_pkg::CNT_W'(NEURONS)) &&
                           ({1'b0, tgt_reg} < tns_pkg::CNT_W'(NEURONS));

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exc_cnt_reg  <= tns_pkg::CNT_W'(51);
            exc_hold_reg <= tns_pkg::HOLD_W'(5);
            inh_hold_reg <= tns_pkg::HOLD_W'(7);
            thr_reg      <= tns_pkg::THR_W'(4);
            exc_wgt_reg  <= tns_pkg::WGT_W'(1);
            inh_wgt_reg  <= tns_pkg::WGT_W'(4);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tns_pkg::CFG_EXC_COUNT:  exc_cnt_reg  <= cfg_data[tns_pkg::CNT_W-1:0];
                tns_pkg::CFG_EXC_HOLD:   exc_hold_reg <= cfg_data[tns_pkg::HOLD_W-1:0];
                tns_pkg::CFG_INH_HOLD:   inh_hold_reg <= cfg_data[tns_pkg::HOLD_W-1:0];
                tns_pkg::CFG_THRESHOLD:  thr_reg      <= $signed(cfg_data[tns_pkg::THR_W-1:0]);
                tns_pkg::CFG_EXC_WEIGHT: exc_wgt_reg  <= cfg_data[tns_pkg::WGT_W-1:0];
                tns_pkg::CFG_INH_WEIGHT: inh_wgt_reg  <= cfg_data[tns_pkg::WGT_W-1:0];
                default: ;
            endcase
        end
    end

    // Memory port control
    always_comb
    begin
        mem_rd      = 1'b0;
        mem_rd_addr = rd_cnt_reg;
        mem_wr      = 1'b0;
        mem_wr_row  = row_ok_reg ? row_q_reg : '0;
        mem_wr_row[tgt_reg[IW-1:0]] = bit_reg;
        if (state_reg == ST_ADJ_RD)
        begin
            mem_rd      = 1'b1;
            mem_rd_addr = src_reg[IW-1:0];
        end
        else if (state_reg == ST_ROWS)
            mem_rd = 1'b1;
        if (state_reg == ST_ADJ_WR)
            mem_wr = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
            adj_mem[src_reg[IW-1:0]] <= mem_wr_row;
        if (mem_rd)
            row_q_reg <= adj_mem[mem_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            row_ok_reg    <= 1'b0;
        end
        else
        begin
            if (mem_wr)
                row_valid_reg[src_reg[IW-1:0]] <= 1'b1;
            if (mem_rd)
                row_ok_reg <= row_valid_reg[mem_rd_addr];
        end
    end

    // Lanes
    always_comb
    begin
        lane_ctrl.clear   = (state_reg == ST_TIMERS);
        lane_ctrl.acc_en  = pend_reg && src_act_reg[pend_idx_reg] && row_ok_reg;
        lane_ctrl.exc_src = (tns_pkg::CNT_W'(pend_idx_reg) < ne);
        lane_ctrl.mul_en  = (state_reg == ST_MUL);
        row_links         = row_q_reg;
    end

    for (genvar t = 0; t < NEURONS; t++)
    begin : g_lane
        tns_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (lane_ctrl),
            .link       (row_links[t]),
            .exc_weight (exc_wgt_reg),
            .inh_weight (inh_wgt_reg),
            .threshold  (thr_reg),
            .fire       (fire[t])
        );
    end

    tns_merge #(.NEURONS(NEURONS)) u_merge (
        .clk       (clk),
        .load      (state_reg == ST_CNT1),
        .active    (active_reg),
        .exc_limit (ne),
        .exc_count (exc_count),
        .inh_count (inh_count)
    );

    always_comb
    begin
        state_wide = '0;
        state_wide[NEURONS-1:0] = active_reg;
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            src_reg       <= '0;
            tgt_reg       <= '0;
            bit_reg       <= 1'b0;
            mask_reg      <= '0;
            active_reg    <= '0;
            src_act_reg   <= '0;
            rd_cnt_reg    <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            for (int s = 0; s < NEURONS; s++)
                timer_reg[s] <= '0;
        end
        else
        begin
            // Hold the result until the output register frees up
            if (state_reg == ST_CNT2 && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            pend_reg     <= (state_reg == ST_ROWS);
            pend_idx_reg <= rd_cnt_reg;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        src_reg  <= s_axis_tdata[5:0];
                        tgt_reg  <= s_axis_tdata[11:6];
                        bit_reg  <= s_axis_tdata[12];
                        mask_reg <= s_axis_tdata[13 +: NEURONS];
                        unique case (tns_pkg::req_t'(s_axis_tuser))
                            tns_pkg::REQ_WRITE: state_reg <= ST_ADJ_RD;
                            tns_pkg::REQ_START:
                            begin
                                for (int s = 0; s < NEURONS; s++)
                                    timer_reg[s] <= '0;
                                active_reg <= s_axis_tdata[13 +: NEURONS];
                                state_reg  <= ST_CNT1;
                            end
                            tns_pkg::REQ_TICK:  state_reg <= ST_TIMERS;
                            default:            state_reg <= ST_CNT1;
                        endcase
                    end
                end
                ST_ADJ_RD:
                    state_reg <= idx_ok ? ST_ADJ_WR : ST_CNT1;
                ST_ADJ_WR:
                    state_reg <= ST_CNT1;
                ST_TIMERS:
                begin
                    // Advance every source timer at once
                    for (int s = 0; s < NEURONS; s++)
                    begin
                        logic [tns_pkg::HOLD_W-1:0] hold;
                        logic [tns_pkg::HOLD_W-1:0] nxt;
                        hold = (tns_pkg::CNT_W'(s) < ne) ? exc_hold_reg : inh_hold_reg;
                        if (timer_reg[s] == '0)
                            nxt = {{(tns_pkg::HOLD_W-1){1'b0}}, active_reg[s]};
                        else if (timer_reg[s] < hold)
                            nxt = timer_reg[s] + 1'b1;
                        else
                            nxt = '0;
                        timer_reg[s]   <= nxt;
                        src_act_reg[s] <= (nxt != '0);
                    end
                    rd_cnt_reg <= '0;
                    state_reg  <= ST_ROWS;
                end
                ST_ROWS:
                begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    if (rd_cnt_reg == IW'(NEURONS - 1))
                        state_reg <= ST_DRAIN;
                end
                ST_DRAIN:
                    state_reg <= ST_MUL;
                ST_MUL:
                    state_reg <= ST_FIRE;
                ST_FIRE:
                begin
                    active_reg <= fire | mask_reg;
                    state_reg  <= ST_CNT1;
                end
                ST_CNT1:
                    state_reg <= ST_CNT2;
                ST_CNT2:
                begin
                    if (out_free)
                    begin
                        out_data_reg  <= {2'b00, inh_count, exc_count, state_wide};
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
